>>> rtl/kfh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kfh_pkg;

    // Length of one counted k-mer, in bases.
    localparam int KMER_LEN    = 4;
    // Width of one histogram bin.
    localparam int COUNT_WIDTH = 32;
    // Window index width, two bits per base, and the number of bins.
    localparam int WIN_BITS    = 2 * KMER_LEN;
    localparam int HIST_DEPTH  = 1 << WIN_BITS;
    // Width of the valid-run counter, which saturates at KMER_LEN.
    localparam int RUN_BITS    = $clog2(KMER_LEN + 1);

    // Item kinds carried on the input side.
    typedef enum logic [1:0] {
        FUNC_BASE  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NOP   = 2'd3
    } t_func;

    // Window update request, applied at the edge where the item is accepted.
    typedef struct packed {
        logic       base;
        logic       clear;
        logic [7:0] symbol;
    } t_win_req;

    // Window state as it stands after the requested update.
    typedef struct packed {
        logic [WIN_BITS-1:0] window;
        logic                hit;
        logic                amb;
    } t_win_stat;

    // Maps a character to {valid, code}; A0 T1 C2 G3, either case.
    function automatic logic [2:0] base_code(input logic [7:0] ch);
        logic [2:0] res;
        case (ch)
            8'h41, 8'h61: res = 3'b100;
            8'h54, 8'h74: res = 3'b101;
            8'h43, 8'h63: res = 3'b110;
            8'h47, 8'h67: res = 3'b111;
            default:      res = 3'b000;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/kmer_frequency_histogram.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Signals                   Contents (lowest bits first)
// s_axis    in   tvalid tready tuser tdata tuser: func; tdata: symbol, bin
// m_axis    out  tvalid tready tdata       counted, kmer_index, bin_count,
//                                          ambiguous_seen
//
// A clear, an unused item kind or a nucleotide that completes no 4-mer
// is done when it is accepted; a nucleotide that completes a 4-mer and a
// bin read wait for the registered read of the bin memory before the
// read-modify-write or the result. Reset is synchronous and active low; it
// and a clear item empty all bins at once through per-bin valid bits.
// A result waits in the output register while the next item is taken, as
// long as that register is free or being emptied in the same cycle.
module kmer_frequency_histogram
    import kfh_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [1:0]  s_axis_tuser,   // func
    input  wire logic [15:0] s_axis_tdata,   // symbol, bin
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata    // counted, kmer_index, bin_count, ambiguous_seen
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RMW,
        S_READ
    } t_state;

    t_state                 r_state;
    logic                   r_out_valid;
    logic                   n_out_valid;
    logic                   r_out_counted;
    logic [7:0]             r_out_kmer;
    logic [31:0]            r_out_count;
    logic                   r_out_amb;
    logic [WIN_BITS-1:0]    r_addr;

    t_func                  s_func;
    logic                   s_accept;
    t_win_req               s_win_req;
    t_win_stat              s_win_next;
    logic                   s_rd_en;
    logic [WIN_BITS-1:0]    s_rd_addr;
    logic [COUNT_WIDTH-1:0] s_rd_data;
    logic [COUNT_WIDTH-1:0] s_inc;
    logic                   s_wr_en;
    logic                   s_out_load;

    assign s_func        = t_func'(s_axis_tuser);
    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // Window tracking for nucleotides and clears.
    assign s_win_req.base   = s_accept && (s_func == FUNC_BASE);
    assign s_win_req.clear  = s_accept && (s_func == FUNC_CLEAR);
    assign s_win_req.symbol = s_axis_tdata[7:0];

    kfh_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (s_win_req),
        .o_next  (s_win_next)
    );

    // Memory read: the completed k-mer's bin, or the requested bin.
    assign s_rd_en   = (s_win_req.base && s_win_next.hit) ||
                       (s_accept && (s_func == FUNC_READ));
    assign s_rd_addr = (s_func == FUNC_BASE) ? s_win_next.window
                                             : WIN_BITS'(s_axis_tdata[15:8]);

    // Saturating increment, written back in the read-modify-write state once the read data is back.
    assign s_inc   = (s_rd_data == {COUNT_WIDTH{1'b1}}) ? s_rd_data
                                                        : s_rd_data + COUNT_WIDTH'(1);
    assign s_wr_en = (r_state == S_RMW);

    kfh_bin_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (s_win_req.clear),
        .i_rd_en   (s_rd_en),
        .i_rd_addr (s_rd_addr),
        .o_rd_data (s_rd_data),
        .i_wr_en   (s_wr_en),
        .i_wr_addr (r_addr),
        .i_wr_data (s_inc)
    );

    // A result is loaded at once for items that need no memory read, else when the memory data is back.
    assign s_out_load  = ((r_state == S_IDLE) && s_accept &&
                          !(s_win_req.base && s_win_next.hit) && (s_func != FUNC_READ)) ||
                         (r_state == S_RMW) || (r_state == S_READ);
    assign n_out_valid = s_out_load || (r_out_valid && !m_axis_tready);

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_out_counted <= 1'b0;
                        r_out_kmer    <= 8'(s_win_next.window);
                        r_out_count   <= '0;
                        r_out_amb     <= s_win_next.amb;
                        r_addr        <= s_win_next.window;
                        if (s_win_req.base && s_win_next.hit) begin
                            r_state <= S_RMW;
                        end else if (s_func == FUNC_READ) begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_RMW: begin
                    r_out_counted <= 1'b1;
                    r_state       <= S_IDLE;
                end
                S_READ: begin
                    r_out_count <= 32'(s_rd_data);
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_amb, r_out_count, r_out_kmer, r_out_counted};

    // A completed k-mer always goes through the read-modify-write state.
    a_hit_rmw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_win_req.base && s_win_next.hit) |=> (r_state == S_RMW))
        else $error("completed k-mer did not start a bin update");

    // The update state ends with a counted result in the output register.
    a_rmw_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RMW) |=> (r_out_valid && r_out_counted && (r_state == S_IDLE)))
        else $error("bin update did not deliver a counted result");

    // A read result never claims a count.
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_out_valid && !r_out_counted))
        else $error("bin read result malformed");

    // A clear shows an empty window and a cleared flag.
    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_win_req.clear |=> (r_out_valid && (r_out_kmer == 8'd0) && !r_out_amb))
        else $error("clear result shows stale window state");

endmodule

`default_nettype wire

>>> rtl/kfh_window.sv
`timescale 1ns / 1ps
`default_nettype none

module kfh_window
    import kfh_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_win_req  i_req,
    output t_win_stat      o_next
);

    logic [WIN_BITS-1:0] r_window, n_window;
    logic [RUN_BITS-1:0] r_run, n_run;
    logic                r_amb, n_amb;
    logic [2:0]          s_code;
    logic                s_hit;

    assign s_code = base_code(i_req.symbol);

    // Next window, run count and sticky flag for the requested update.
    always_comb begin
        n_window = r_window;
        n_run    = r_run;
        n_amb    = r_amb;
        s_hit    = 1'b0;
        if (i_req.clear) begin
            n_window = '0;
            n_run    = '0;
            n_amb    = 1'b0;
        end else if (i_req.base) begin
            if (!s_code[2]) begin
                n_run = '0;
                n_amb = 1'b1;
            end else begin
                n_window = WIN_BITS'({r_window, s_code[1:0]});
                if (r_run < RUN_BITS'(KMER_LEN)) begin
                    n_run = r_run + RUN_BITS'(1);
                end
                s_hit = (n_run == RUN_BITS'(KMER_LEN));
            end
        end
    end

    // Window state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_run    <= '0;
            r_amb    <= 1'b0;
        end else begin
            r_window <= n_window;
            r_run    <= n_run;
            r_amb    <= n_amb;
        end
    end

    assign o_next.window = n_window;
    assign o_next.hit    = s_hit;
    assign o_next.amb    = n_amb;

endmodule

`default_nettype wire

>>> rtl/kfh_bin_store.sv
`timescale 1ns / 1ps
`default_nettype none

module kfh_bin_store
    import kfh_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_clear,
    input  wire logic                   i_rd_en,
    input  wire logic [WIN_BITS-1:0]    i_rd_addr,
    output logic      [COUNT_WIDTH-1:0] o_rd_data,
    input  wire logic                   i_wr_en,
    input  wire logic [WIN_BITS-1:0]    i_wr_addr,
    input  wire logic [COUNT_WIDTH-1:0] i_wr_data
);

    logic [COUNT_WIDTH-1:0] r_mem [HIST_DEPTH];
    logic [HIST_DEPTH-1:0]  r_valid;
    logic [COUNT_WIDTH-1:0] r_rd_data;
    logic                   r_rd_valid;

    // Bin memory, one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Per-bin valid bits; a bin that was never written since a clear reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_clear) begin
                r_valid <= '0;
            end else if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

`default_nettype wire

>>> dv/kmer_frequency_histogram_tb.sv
`timescale 1ns / 1ps

module kmer_frequency_histogram_tb;
    import kfh_pkg::*;

    // Quiet tail: no idling once this few items are left to send.
    localparam int TAIL_ITEMS   = 150;
    localparam int RANDOM_ITEMS = 1400;
    localparam int STUCK_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;

    // One input transaction as the sender sees it.
    typedef struct packed {
        t_func      func;
        logic [7:0] symbol;
        logic [7:0] bin;
    } t_seq_item;

    // One output transaction, split into its fields.
    typedef struct packed {
        logic                   counted;
        logic [7:0]             kmer;
        logic [31:0]            count;
        logic                   amb;
    } t_tally;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [1:0]  s_axis_tuser = 2'd0;     // func
    logic [15:0] s_axis_tdata = 16'd0;    // symbol, bin
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;            // counted, kmer_index, bin_count, ambiguous_seen

    // Shadow copy of the histogram and the window state.
    logic [COUNT_WIDTH-1:0] nt_hist [HIST_DEPTH];
    logic [WIN_BITS-1:0]    nt_window;
    int                     nt_run;
    logic                   nt_amb;

    t_seq_item seq_items_q [$];
    t_tally    tally_q [$];
    t_seq_item next_item;
    t_tally    got, want;

    logic [7:0] nt_chars [8] = '{"A", "T", "C", "G", "a", "t", "c", "g"};

    logic in_fire = 1'b0;
    logic quiet_tail = 1'b0;
    int   idle_mode = 0;
    int   mode_left = 0;
    int   in_gap = 0;
    int   out_stall = 0;
    int   n_errors = 0;
    int   stuck_cycles = 0;

    kmer_frequency_histogram i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Base code of a character, or -1 when it is not a nucleotide.
    function automatic int nt_code(input logic [7:0] ch);
        case (ch)
            "A", "a": return 0;
            "T", "t": return 1;
            "C", "c": return 2;
            "G", "g": return 3;
            default:  return -1;
        endcase
    endfunction

    function automatic void clear_tally();
        foreach (nt_hist[i]) nt_hist[i] = '0;
        nt_window = '0;
        nt_run    = 0;
        nt_amb    = 1'b0;
    endfunction

    // Applies one accepted item to the shadow state and returns its result.
    function automatic t_tally tally_item(input t_seq_item it);
        t_tally r;
        int     code;
        r = '0;
        case (it.func)
            FUNC_BASE: begin
                code = nt_code(it.symbol);
                if (code < 0) begin
                    // An ambiguous character restarts the run but keeps the window.
                    nt_run = 0;
                    nt_amb = 1'b1;
                end else begin
                    nt_window = {nt_window[WIN_BITS-3:0], code[1:0]};
                    if (nt_run < KMER_LEN) nt_run++;
                    if (nt_run >= KMER_LEN) begin
                        // Saturated bins still report the count event.
                        if (nt_hist[nt_window] != {COUNT_WIDTH{1'b1}})
                            nt_hist[nt_window] = nt_hist[nt_window] + 1'b1;
                        r.counted = 1'b1;
                    end
                end
            end
            FUNC_READ: begin
                r.count = nt_hist[it.bin % HIST_DEPTH];
            end
            FUNC_CLEAR: begin
                clear_tally();
            end
            default: ;
        endcase
        r.kmer = nt_window;
        r.amb  = nt_amb;
        return r;
    endfunction

    function automatic void queue_item(input t_func f, input logic [7:0] sym,
                                       input logic [7:0] b);
        t_seq_item it;
        it.func   = f;
        it.symbol = sym;
        it.bin    = b;
        seq_items_q.insert(seq_items_q.size(), it);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Decides whether an idle burst starts now, by the current idling mode.
    function automatic bit start_idle();
        if (idle_mode == 0 || quiet_tail) return 1'b0;
        return $urandom_range(0, (idle_mode == 1) ? 15 : 3) == 0;
    endfunction

    // Input driver: presents the next pending item, with random gaps.
    always @(negedge i_clk) begin
        if (i_rst_n && (in_fire || !s_axis_tvalid)) begin
            if (in_gap > 0) begin
                in_gap = in_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (in_fire && start_idle()) begin
                in_gap = $urandom_range(1, 14) - 1;
                s_axis_tvalid <= 1'b0;
            end else if (seq_items_q.size() != 0) begin
                next_item = seq_items_q.pop_front();
                s_axis_tuser  <= next_item.func;
                s_axis_tdata  <= {next_item.bin, next_item.symbol};
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output ready driver: random stall bursts.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (out_stall > 0) begin
            out_stall = out_stall - 1;
            m_axis_tready <= 1'b0;
        end else if (start_idle()) begin
            out_stall = $urandom_range(1, 14) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: predicts each accepted item and checks each accepted result.
    always @(posedge i_clk) begin
        in_fire    <= i_rst_n && s_axis_tvalid && s_axis_tready;
        quiet_tail <= seq_items_q.size() < TAIL_ITEMS;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            tally_q.insert(tally_q.size(),
                           tally_item({t_func'(s_axis_tuser), s_axis_tdata[7:0],
                                       s_axis_tdata[15:8]}));
            // The idling mode changes every few dozen transactions.
            if (mode_left == 0) begin
                idle_mode <= $urandom_range(0, 2);
                mode_left <= $urandom_range(40, 160);
            end else begin
                mode_left <= mode_left - 1;
            end
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.counted = m_axis_tdata[0];
            got.kmer    = m_axis_tdata[8:1];
            got.count   = m_axis_tdata[40:9];
            got.amb     = m_axis_tdata[41];
            if (tally_q.size() == 0) begin
                $display("%0t: unexpected result counted=%0d kmer=%02h count=%0d amb=%0d",
                         $time, got.counted, got.kmer, got.count, got.amb);
                n_errors++;
            end else begin
                want = tally_q.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected counted=%0d kmer=%02h count=%0d amb=%0d",
                             $time, want.counted, want.kmer, want.count, want.amb);
                    $display("%0t:          actual   counted=%0d kmer=%02h count=%0d amb=%0d",
                             $time, got.counted, got.kmer, got.count, got.amb);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == STUCK_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int         total;
        int         pick;
        int         run_len;
        int         code;
        bit         same_base;
        logic [7:0] hot_bins [4];
        hot_bins = '{8'h00, 8'h55, 8'hAA, 8'hFF};
        clear_tally();

        // Reads of an empty store at both ends of the bin range.
        queue_item(FUNC_READ, 8'hFF, 8'h00);
        queue_item(FUNC_READ, 8'h00, 8'hFF);
        // Upper case bases; the fourth completes the first 4-mer.
        queue_item(FUNC_BASE, "A", 8'hFF);
        queue_item(FUNC_BASE, "C", 8'h00);
        queue_item(FUNC_BASE, "G", 8'hFF);
        queue_item(FUNC_BASE, "T", 8'h00);
        // Lower case bases keep counting.
        queue_item(FUNC_BASE, "a", 8'hFF);
        queue_item(FUNC_BASE, "c", 8'h00);
        queue_item(FUNC_BASE, "g", 8'hFF);
        queue_item(FUNC_BASE, "t", 8'h00);
        // Ambiguous characters, including both byte extremes.
        queue_item(FUNC_BASE, 8'h00, 8'hFF);
        queue_item(FUNC_BASE, 8'hFF, 8'h00);
        queue_item(FUNC_BASE, "N", 8'h5A);
        // Three bases after an ambiguity do not count; the fourth does.
        queue_item(FUNC_BASE, "G", 8'h00);
        queue_item(FUNC_BASE, "G", 8'h00);
        queue_item(FUNC_BASE, "G", 8'h00);
        queue_item(FUNC_BASE, "g", 8'h00);
        queue_item(FUNC_READ, 8'h00, 8'hFF);
        queue_item(FUNC_READ, 8'hFF, 8'h2D);
        // The unused kind changes nothing.
        queue_item(FUNC_NOP, "A", 8'hAA);
        // Clear, then the store reads empty and the run starts over.
        queue_item(FUNC_CLEAR, 8'hFF, 8'hFF);
        queue_item(FUNC_READ, 8'h00, 8'h2D);
        queue_item(FUNC_BASE, "t", 8'hFF);
        queue_item(FUNC_READ, 8'hFF, 8'hFF);

        // Random part: mostly runs of bases, with ambiguities, reads, unused items and clears.
        total = seq_items_q.size() + RANDOM_ITEMS;
        while (seq_items_q.size() < total) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                run_len   = $urandom_range(4, 20);
                same_base = $urandom_range(0, 3) == 0;
                code      = $urandom_range(0, 3);
                repeat (run_len) begin
                    if (!same_base) code = $urandom_range(0, 3);
                    queue_item(FUNC_BASE, nt_chars[code + 4 * $urandom_range(0, 1)],
                               rand_byte());
                end
            end else if (pick < 82) begin
                queue_item(FUNC_BASE, rand_byte(), rand_byte());
            end else if (pick < 95) begin
                if ($urandom_range(0, 1))
                    queue_item(FUNC_READ, rand_byte(), hot_bins[$urandom_range(0, 3)]);
                else
                    queue_item(FUNC_READ, rand_byte(), rand_byte());
            end else if (pick < 98) begin
                queue_item(FUNC_NOP, rand_byte(), rand_byte());
            end else begin
                queue_item(FUNC_CLEAR, rand_byte(), rand_byte());
            end
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (seq_items_q.size() != 0 || s_axis_tvalid || tally_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_errors == 0 && tally_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
